/* sv/sab_pkg.sv */
package sab_pkg;

  localparam int MAX_LEN_DEF  = 1024;
  localparam int ALPHABET_DEF = 26;
  localparam int SYM_W  = 5;
  localparam int NODE_W = 12;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             restart;
  } sab_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] last_node;
    logic [NODE_W-1:0] node_count;
    logic              cloned;
    logic              overflow;
  } sab_out_t;

  // Datapath commands issued by the controller.
  localparam logic [3:0] CMD_NONE     = 4'd0;
  localparam logic [3:0] CMD_START    = 4'd1;
  localparam logic [3:0] CMD_NEWNODE  = 4'd2;
  localparam logic [3:0] CMD_RD_P     = 4'd3;
  localparam logic [3:0] CMD_WALK1    = 4'd4;
  localparam logic [3:0] CMD_RD_Q     = 4'd5;
  localparam logic [3:0] CMD_DECIDE   = 4'd6;
  localparam logic [3:0] CMD_COPY     = 4'd7;
  localparam logic [3:0] CMD_LINKS    = 4'd8;
  localparam logic [3:0] CMD_CLR_ROOT = 4'd9;
  localparam logic [3:0] CMD_WALK2    = 4'd10;
  localparam logic [3:0] CMD_FINISH   = 4'd11;
  localparam logic [3:0] CMD_CLR_NP   = 4'd12;

  typedef struct packed {
    logic [3:0] op;
  } sab_cmd_t;

  typedef struct packed {
    logic skip;        // symbol ignored or dropped
    logic root_dirty;  // root must be cleared before use
    logic edge_hit;    // transition of p on the symbol is the awaited value
    logic link_zero;   // suffix link of p is no node
    logic solid;       // len[q] == len[p] + 1
    logic ci_last;     // clear index is at the last symbol
    logic copy_done;
  } sab_sts_t;

endpackage

/* sv/sab_ctrl.sv */
module sab_ctrl import sab_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_busy,
  input  sab_sts_t sts,
  output sab_cmd_t cmd,
  output logic     idle,
  output logic     done
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_RDP   = 4'd2;
  localparam logic [3:0] S_WALK1 = 4'd3;
  localparam logic [3:0] S_RDQ   = 4'd4;
  localparam logic [3:0] S_DEC   = 4'd5;
  localparam logic [3:0] S_COPY  = 4'd6;
  localparam logic [3:0] S_LINKS = 4'd7;
  localparam logic [3:0] S_RDP2  = 4'd8;
  localparam logic [3:0] S_WALK2 = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;
  localparam logic [3:0] S_NCLR  = 4'd11;
  localparam logic [3:0] S_RCLR  = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  logic [3:0] state_r, state_nxt;

  // Sequencer: at most one command per step; walks loop over read/check.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = CMD_NONE;
    done      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.op    = CMD_START;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.root_dirty) begin
          state_nxt = S_RCLR;
        end else if (sts.skip) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op    = CMD_NEWNODE;
          state_nxt = S_NCLR;
        end
      end
      S_RCLR: begin
        cmd.op = CMD_CLR_ROOT;
        if (sts.ci_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_NCLR: begin
        cmd.op = CMD_CLR_NP;
        if (sts.ci_last) begin
          state_nxt = S_RDP;
        end
      end
      S_RDP: begin
        cmd.op    = CMD_RD_P;
        state_nxt = S_WALK1;
      end
      S_WALK1: begin
        cmd.op = CMD_WALK1;
        if (sts.edge_hit) begin
          state_nxt = S_RDQ;
        end else if (sts.link_zero) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_RDP;
        end
      end
      S_RDQ: begin
        cmd.op    = CMD_RD_Q;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (sts.solid) begin
          state_nxt = S_FIN;
        end else begin
          cmd.op    = CMD_DECIDE;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        cmd.op = CMD_COPY;
        if (sts.copy_done) begin
          state_nxt = S_LINKS;
        end
      end
      S_LINKS: begin
        cmd.op    = CMD_LINKS;
        state_nxt = S_RDP2;
      end
      S_RDP2: begin
        cmd.op    = CMD_RD_P;
        state_nxt = S_WALK2;
      end
      S_WALK2: begin
        cmd.op = CMD_WALK2;
        if (!sts.edge_hit || sts.link_zero) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_RDP2;
        end
      end
      S_FIN: begin
        cmd.op    = CMD_FINISH;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign idle = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/sab_dp.sv */
module sab_dp import sab_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  sab_cmd_t cmd,
  input  sab_in_t  in_word,
  output sab_sts_t sts,
  output sab_out_t res
);

  localparam int NODE_CAP = 2 * MAX_LEN;
  localparam int NW   = $clog2(NODE_CAP + 1);
  localparam int LW   = $clog2(MAX_LEN + 1);
  localparam int AW   = $clog2(ALPHABET);
  localparam int SW   = (AW > SYM_W) ? AW : SYM_W;
  localparam int DEP  = NODE_CAP + 1;
  localparam int TDEP = DEP * ALPHABET;
  localparam int TW   = $clog2(TDEP);

  // Node storage: lengths, suffix links and the transition table.
  logic [LW-1:0] len_mem  [DEP];
  logic [NW-1:0] link_mem [DEP];
  logic [NW-1:0] trn_mem  [TDEP];

  logic [NW-1:0] total_r, last_r, p_r, np_r, q_r, nq_r;
  logic [LW-1:0] lenp_r, lenlast_r;
  logic [SW-1:0] sym_r;
  logic          skip_r, full_r, split_r, root_dirty_r;
  logic [AW-1:0] ci_r, cw_r;
  logic          cv_r;

  logic [TW-1:0] trn_raddr, trn_waddr;
  logic [NW-1:0] trn_wdata;
  logic          trn_we;
  logic [NW-1:0] trn_rd_r;
  logic [NW-1:0] node_raddr;
  logic [LW-1:0] len_rd_r;
  logic [NW-1:0] link_rd_r;
  logic [NW-1:0] link_waddr, link_wdata;
  logic          link_we;
  logic [NW-1:0] len_waddr;
  logic [LW-1:0] len_wdata;
  logic          len_we;
  logic [NW-1:0] node_new;
  logic [LW-1:0] lenp_inc;
  logic          hit, ci_last, copy_last, sym_ok, full_now;
  logic [AW-1:0] sym_a;

  function automatic logic [TW-1:0] taddr(input logic [NW-1:0] n, input logic [AW-1:0] s);
    taddr = TW'(n * ALPHABET) + TW'(s);
  endfunction

  assign sym_a     = sym_r[AW-1:0];
  assign node_new  = total_r + 1'b1;
  assign lenp_inc  = lenp_r + 1'b1;
  assign hit       = split_r ? (trn_rd_r == q_r) : (trn_rd_r != '0);
  assign ci_last   = (32'(ci_r) == ALPHABET - 1);
  assign copy_last = cv_r && (32'(cw_r) == ALPHABET - 1);
  assign sym_ok    = (32'(in_word.symbol) < ALPHABET);
  assign full_now  = !in_word.restart &&
                     ((32'(lenlast_r) >= MAX_LEN) || (32'(total_r) + 2 > NODE_CAP));

  // Read-address and write selection per command.
  always_comb begin
    trn_raddr  = taddr(p_r, sym_a);
    node_raddr = p_r;
    trn_we     = 1'b0;
    trn_waddr  = taddr(p_r, sym_a);
    trn_wdata  = '0;
    link_we    = 1'b0;
    link_waddr = np_r;
    link_wdata = '0;
    len_we     = 1'b0;
    len_waddr  = np_r;
    len_wdata  = '0;
    case (cmd.op)
      CMD_CLR_ROOT: begin
        trn_we     = 1'b1;
        trn_waddr  = taddr(NW'(1), ci_r);
        len_we     = 1'b1;
        len_waddr  = NW'(1);
        link_we    = 1'b1;
        link_waddr = NW'(1);
      end
      CMD_NEWNODE: begin
        len_we    = 1'b1;
        len_waddr = node_new;
        len_wdata = lenlast_r + 1'b1;
      end
      CMD_CLR_NP: begin
        trn_we    = 1'b1;
        trn_waddr = taddr(np_r, ci_r);
      end
      CMD_WALK1: begin
        trn_we    = !hit;
        trn_wdata = np_r;
      end
      CMD_RD_Q: node_raddr = q_r;
      CMD_DECIDE: begin
        len_we     = 1'b1;
        len_waddr  = node_new;
        len_wdata  = lenp_inc;
        link_we    = 1'b1;
        link_waddr = node_new;
        link_wdata = link_rd_r;
      end
      CMD_COPY: begin
        trn_raddr = taddr(q_r, ci_r);
        trn_we    = cv_r;
        trn_waddr = taddr(nq_r, cw_r);
        trn_wdata = trn_rd_r;
      end
      CMD_LINKS: begin
        link_we    = 1'b1;
        link_waddr = q_r;
        link_wdata = nq_r;
      end
      CMD_WALK2: begin
        trn_we    = hit;
        trn_wdata = nq_r;
      end
      CMD_FINISH: begin
        link_we    = 1'b1;
        link_waddr = np_r;
        link_wdata = split_r ? nq_r : ((p_r == '0) ? NW'(1) : q_r);
      end
      default: ;
    endcase
  end

  // Memory ports, one write and one registered read each per cycle.
  always_ff @(posedge clk) begin
    if (trn_we) trn_mem[trn_waddr] <= trn_wdata;
    trn_rd_r <= trn_mem[trn_raddr];
    if (len_we) len_mem[len_waddr] <= len_wdata;
    len_rd_r <= len_mem[node_raddr];
    if (link_we) link_mem[link_waddr] <= link_wdata;
    link_rd_r <= link_mem[node_raddr];
  end

  // Control and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= NW'(1);
      last_r       <= NW'(1);
      lenlast_r    <= '0;
      root_dirty_r <= 1'b1;
      ci_r         <= '0;
      cv_r         <= 1'b0;
      split_r      <= 1'b0;
      skip_r       <= 1'b0;
      full_r       <= 1'b0;
    end else begin
      case (cmd.op)
        CMD_START: begin
          sym_r   <= SW'(in_word.symbol);
          split_r <= 1'b0;
          if (in_word.restart) begin
            total_r      <= NW'(1);
            last_r       <= NW'(1);
            lenlast_r    <= '0;
            root_dirty_r <= 1'b1;
          end
          skip_r <= !sym_ok || full_now;
          full_r <= sym_ok && full_now;
        end
        CMD_CLR_ROOT: begin
          ci_r <= ci_last ? '0 : ci_r + 1'b1;
          if (ci_last) root_dirty_r <= 1'b0;
        end
        CMD_NEWNODE: begin
          np_r    <= node_new;
          total_r <= node_new;
          p_r     <= last_r;
        end
        CMD_CLR_NP: ci_r <= ci_last ? '0 : ci_r + 1'b1;
        CMD_WALK1: begin
          if (hit) begin
            q_r    <= trn_rd_r;
            lenp_r <= len_rd_r;
          end else begin
            p_r <= link_rd_r;
          end
        end
        CMD_DECIDE: begin
          nq_r    <= node_new;
          total_r <= node_new;
          split_r <= 1'b1;
        end
        CMD_COPY: begin
          if (copy_last) begin
            cv_r <= 1'b0;
            ci_r <= '0;
          end else begin
            cw_r <= ci_r;
            cv_r <= 1'b1;
            if (!ci_last) ci_r <= ci_r + 1'b1;
          end
        end
        CMD_WALK2: begin
          if (hit) p_r <= link_rd_r;
        end
        CMD_FINISH: begin
          last_r    <= np_r;
          lenlast_r <= lenlast_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.skip       = skip_r;
    sts.root_dirty = root_dirty_r;
    sts.edge_hit   = hit;
    sts.link_zero  = (link_rd_r == '0);
    sts.solid      = (len_rd_r == lenp_inc);
    sts.ci_last    = ci_last;
    sts.copy_done  = copy_last;
  end

  assign res.last_node  = NODE_W'(last_r);
  assign res.node_count = NODE_W'(total_r);
  assign res.cloned     = split_r;
  assign res.overflow   = full_r;

endmodule

/* sv/suffix_automaton_builder_unit.sv */
// Channel | Direction | Ports
// in      | input     | in_valid, in_ready, in_data (sab_in_t)
// out     | output    | out_valid, out_ready, out_data (sab_out_t)
//
// One word is processed at a time. An added symbol walks the suffix links from the last node
// until a step meets an existing transition or a zero link; a met node that is not solid is
// cloned, copying all its transitions, and a second walk then redirects the checked transitions.
// The added node's transitions are cleared in a pass over the alphabet; a restart or the first
// word after reset first clears the root. An ignored or dropped symbol adds no node.
// A stalled result is held in the output register; the next word can be accepted from the cycle after the load.
module suffix_automaton_builder_unit import sab_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sab_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sab_out_t out_data
);

  sab_cmd_t cmd;
  sab_sts_t sts;
  sab_out_t res;
  logic     idle, done, in_fire;

  assign in_ready = idle;
  assign in_fire  = in_valid && in_ready;

  sab_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy(out_valid && !out_ready),
    .sts, .cmd, .idle, .done
  );

  sab_dp #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_dp (
    .clk, .rst_n, .cmd, .in_word(in_data), .sts, .res
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) out_data <= res;
  end

endmodule

/* sv/sab_checker.sv */
module sab_checker import sab_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input sab_out_t out_data
);

  // A held result stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Node count never below one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.node_count != '0)
    else $error("empty automaton");

  // A clone and an overflow never share a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.cloned && out_data.overflow))
    else $error("clone on dropped symbol");

  // No new word is taken in the cycle after one was accepted.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("double accept");

endmodule

bind suffix_automaton_builder_unit sab_checker u_sab_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
